// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition must never hold");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle consequence violated");
`else
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/strot_pkg.sv
// ----------------------------------------------------------------------------
// strot_pkg
// shared types and constants of the square tile rotator
// ----------------------------------------------------------------------------
package strot_pkg;

    localparam int PIXEL_W    = 16;
    localparam int SIDE_W     = 6;
    localparam int COORD_W    = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;

    // register index, taken from paddr above the byte offset
    localparam logic [APB_ADDR_W-3:0] REG_TILE_SIDE = 1'b0;

    // one queued request: where to write, where to read, and the pixel
    typedef struct packed {
        logic                       bank;
        logic [COORD_W-1:0]         wr_row;
        logic [COORD_W-1:0]         wr_col;
        logic [COORD_W-1:0]         rd_row;
        logic [COORD_W-1:0]         rd_col;
        logic                       last;
        logic signed [PIXEL_W-1:0]  pixel;
    } cmd_t;

    // configuration seen by the front end
    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic              restart;
    } cfg_t;

endpackage

// File: rtl/strot_front.sv
// ----------------------------------------------------------------------------
// strot_front
// accepts pixels, tracks the tile position and bank, and issues requests
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strot_front #(
    parameter int MAX_SIDE = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  strot_pkg::cfg_t                        cfg,
    input  logic                                   busy,
    input  logic                                   q_full,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [strot_pkg::PIXEL_W-1:0]   s_pixel_in,
    output logic                                   push,
    output strot_pkg::cmd_t                        cmd
);
    import strot_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int NW = SIDE_W + 1;

    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          bank_reg, bank_next;
    logic [NW-1:0] side;
    logic [NW-1:0] src_row;
    logic          col_wrap;
    logic          row_wrap;

    always_comb begin
        if (cfg.side == '0) begin
            side = NW'(1);
        end else if (NW'(cfg.side) > NW'(MAX_SIDE)) begin
            side = NW'(MAX_SIDE);
        end else begin
            side = NW'(cfg.side);
        end
    end

    assign col_wrap = (NW'(col_reg) + NW'(1)) >= side;
    assign row_wrap = (NW'(row_reg) + NW'(1)) >= side;
    assign src_row  = side - NW'(1) - NW'(col_reg);

    assign s_ready = !q_full && !busy;
    assign push    = s_valid && s_ready;

    always_comb begin
        cmd.bank   = bank_reg;
        cmd.wr_row = COORD_W'(row_reg);
        cmd.wr_col = COORD_W'(col_reg);
        cmd.rd_row = COORD_W'(src_row);
        cmd.rd_col = COORD_W'(row_reg);
        cmd.last   = col_wrap && row_wrap;
        cmd.pixel  = s_pixel_in;
    end

    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        bank_next = bank_reg;
        if (cfg.restart) begin
            row_next = '0;
            col_next = '0;
        end else if (push) begin
            if (col_wrap) begin
                col_next = '0;
                if (row_wrap) begin
                    row_next  = '0;
                    bank_next = !bank_reg;
                end else begin
                    row_next = row_reg + CW'(1);
                end
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            bank_reg <= 1'b0;
        end else begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            bank_reg <= bank_next;
        end
    end

    `ASSERT_NEVER(a_pos_in_tile, aclk, aresetn, (NW'(row_reg) >= side) || (NW'(col_reg) >= side))
    `ASSERT_NEXT(a_bank_swap, aclk, aresetn, push && cmd.last, bank_reg != $past(bank_reg))
    `ASSERT_NEXT(a_bank_hold, aclk, aresetn, !(push && cmd.last), bank_reg == $past(bank_reg))

endmodule

// File: rtl/strot_queue.sv
// ----------------------------------------------------------------------------
// strot_queue
// two-entry request queue between front and back end
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strot_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  strot_pkg::cmd_t push_data,
    input  logic            pop,
    output strot_pkg::cmd_t head,
    output logic            empty,
    output logic            full
);
    import strot_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == NW'(DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && full && !pop)
    `ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && empty)
    `ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + NW'(1))

endmodule

// File: rtl/strot_back.sv
// ----------------------------------------------------------------------------
// strot_back
// double-buffered tile store: clears after reset, then writes the incoming
// pixel and reads the rotated pixel of the previous tile per request
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strot_back #(
    parameter int MAX_SIDE   = 32,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   empty,
    input  strot_pkg::cmd_t                        head,
    output logic                                   pop,
    output logic                                   busy,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [strot_pkg::PIXEL_W-1:0]   m_pixel_out,
    output logic                                   m_tile_end
);
    import strot_pkg::*;

    localparam int BANK_SIZE = MAX_SIDE * MAX_SIDE;
    localparam int DEPTH     = 2 * BANK_SIZE;
    localparam int AW        = $clog2(DEPTH);
    localparam int WIDE      = (PIXEL_BITS > PIXEL_W) ? PIXEL_BITS : PIXEL_W;

    logic [PIXEL_BITS-1:0] mem [DEPTH];

    logic                  clearing_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [PIXEL_BITS-1:0] rdata_reg;
    logic                  last_reg;

    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [PIXEL_BITS-1:0] mem_wdata;
    logic [WIDE-1:0]       wide_in;
    logic [WIDE-1:0]       wide_out;

    assign waddr = (head.bank ? AW'(BANK_SIZE) : AW'(0))
                 + AW'(head.wr_row) * AW'(MAX_SIDE) + AW'(head.wr_col);
    assign raddr = (head.bank ? AW'(0) : AW'(BANK_SIZE))
                 + AW'(head.rd_row) * AW'(MAX_SIDE) + AW'(head.rd_col);

    assign pop  = !empty && !clearing_reg && (!out_valid_reg || m_ready);
    assign busy = clearing_reg;

    assign wide_in   = WIDE'($unsigned(head.pixel));
    assign mem_we    = clearing_reg || pop;
    assign mem_waddr = clearing_reg ? clr_addr_reg : waddr;
    assign mem_wdata = clearing_reg ? '0 : wide_in[PIXEL_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop) begin
            rdata_reg <= mem[raddr];
            last_reg  <= head.last;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign wide_out    = WIDE'(rdata_reg);
    assign m_valid     = out_valid_reg;
    assign m_pixel_out = signed'(wide_out[PIXEL_W-1:0]);
    assign m_tile_end  = last_reg;

    `ASSERT_NEXT(a_clear_once, aclk, aresetn, !clearing_reg, !clearing_reg)
    `ASSERT_NEVER(a_no_out_in_clear, aclk, aresetn, out_valid_reg && clearing_reg)
    `ASSERT_NEXT(a_pop_shows, aclk, aresetn, pop, out_valid_reg)

endmodule

// File: rtl/square_tile_rotate_90_clockwise.sv
// ----------------------------------------------------------------------------
// square_tile_rotate_90_clockwise
// rotates square pixel tiles by 90 degrees clockwise through a double buffer
// ----------------------------------------------------------------------------
// After reset the tile store (2*MAX_SIDE*MAX_SIDE entries, 2048 at the default
// size) is cleared one entry per clock, with s_ready low until it is done;
// configuration writes are taken meanwhile. Then one pixel is taken per
// clock while the request queue has room, and one result pixel is returned
// per input pixel through the queue and the registered store read; the store
// does one write and one read per request. Results are the previous tile
// rotated clockwise in row-major order (first tile reads zeros); m_tile_end
// marks a tile's last pixel, and writing tile_side restarts the current tile.
// ----------------------------------------------------------------------------
module square_tile_rotate_90_clockwise #(
    parameter int MAX_SIDE   = 32,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [strot_pkg::PIXEL_W-1:0]      s_pixel_in,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [strot_pkg::PIXEL_W-1:0]      m_pixel_out,
    output logic                                      m_tile_end,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [strot_pkg::APB_ADDR_W-1:0]          paddr,
    input  logic [strot_pkg::APB_DATA_W-1:0]          pwdata,
    output logic [strot_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                      pready
);
    import strot_pkg::*;

    logic [SIDE_W-1:0] tile_side_reg, tile_side_next;
    logic              cfg_we;
    logic              sel_tile_side;
    cfg_t              cfg;
    cmd_t              front_cmd;
    cmd_t              q_head;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              busy;

    assign sel_tile_side = (paddr[APB_ADDR_W-1:2] == REG_TILE_SIDE);
    assign cfg_we        = psel && penable && pwrite && sel_tile_side;
    assign pready        = 1'b1;
    assign prdata        = sel_tile_side ? APB_DATA_W'(tile_side_reg) : '0;

    assign tile_side_next = cfg_we ? pwdata[SIDE_W-1:0] : tile_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_side_reg <= SIDE_RESET;
        end else begin
            tile_side_reg <= tile_side_next;
        end
    end

    assign cfg.side    = tile_side_reg;
    assign cfg.restart = cfg_we;

    strot_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .busy       (busy),
        .q_full     (q_full),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel_in (s_pixel_in),
        .push       (push),
        .cmd        (front_cmd)
    );

    strot_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_cmd),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    strot_back #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .empty       (q_empty),
        .head        (q_head),
        .pop         (pop),
        .busy        (busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_tile_end  (m_tile_end)
    );

endmodule
